/* hdl/triangular_weighted_pick_unit_macros.svh */
// Assertion macros shared by the triangular weighted pick unit modules.
// Needs nothing else; included by files that carry concurrent checks.
`ifndef TRIANGULAR_WEIGHTED_PICK_UNIT_MACROS_SVH
`define TRIANGULAR_WEIGHTED_PICK_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TWP_ASSERT_NOW(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (expr)) \
        else $error("triangular_weighted_pick_unit: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define TWP_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (expr)) \
        else $error("triangular_weighted_pick_unit: next-cycle check failed");

`endif

/* hdl/twp_pkg.sv */
`timescale 1ns / 1ps
// Shared widths, constants and payload types of the triangular weighted pick unit.
// No dependencies.
package twp_pkg;

    localparam int COUNT_BITS  = 16;
    localparam int RANDOM_BITS = 32;
    localparam int PICK_BITS   = 16;

    // n(n+1)/2 < 2^(2*COUNT_BITS-1)
    localparam int TRI_BITS   = 2 * COUNT_BITS - 1;
    localparam int PROD_BITS  = 2 * COUNT_BITS + 1;
    // radicand 8*choice+1
    localparam int RAD_BITS   = TRI_BITS + 3;
    localparam int ROOT_BITS  = (RAD_BITS + 1) / 2;
    localparam int SQ_W       = RAD_BITS + 1;

    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_BITS = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [COUNT_BITS-1:0]  entry_count;
        logic [RANDOM_BITS-1:0] random_word;
    } t_item;

    typedef struct packed {
        logic [PICK_BITS-1:0] pick_index;
        logic                 bad_count;
    } t_result;

    // Classified item as it travels from front to back.
    typedef struct packed {
        logic [COUNT_BITS-1:0]  count;
        logic [RANDOM_BITS-1:0] rnd;
        logic [TRI_BITS-1:0]    tri_num;
        logic                   bad;
    } t_job;

    typedef struct packed {
        logic full;
        logic not_empty;
    } t_q_status;

endpackage

/* hdl/triangular_weighted_pick_unit.sv */
`timescale 1ns / 1ps
// Top level of the triangular weighted pick unit.
// Depends on twp_pkg, twp_front, twp_queue and twp_back.

// Picks an index in 0..n-1 with weight n-i for index i, from a count n and a
// random word. An item is taken on each clock edge where start is high and
// busy is low; a new item can be taken every cycle. Each item gives exactly
// one result, on o_result for one cycle with o_result_valid high, in order,
// after the item has passed the front register, the job queue, the remainder
// pipeline, one stage per random bit, the square root pipeline, one stage per
// root bit, and the output register. The results cannot be held off, so the
// back end never stalls and busy stays low in normal use. A count of zero
// returns index 0 with bad_count set.
module triangular_weighted_pick_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  twp_pkg::t_item    i_item,
    output logic              busy,
    output logic              o_result_valid,
    output twp_pkg::t_result  o_result
);
    import twp_pkg::*;

    t_q_status q_status;
    t_job      push_job;
    t_job      head_job;
    logic      push;
    logic      pop;

    twp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_item     (i_item),
        .o_busy     (busy),
        .i_q_status (q_status),
        .o_push     (push),
        .o_job      (push_job)
    );

    twp_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_head   (head_job),
        .o_status (q_status)
    );

    twp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_head     (head_job),
        .o_pop      (pop),
        .o_valid    (o_result_valid),
        .o_result   (o_result)
    );

endmodule

/* hdl/twp_front.sv */
`timescale 1ns / 1ps
// Front end: takes items, flags a zero count and forms the triangular number.
// Depends on twp_pkg.
module twp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  twp_pkg::t_item    i_item,
    output logic              o_busy,
    input  twp_pkg::t_q_status i_q_status,
    output logic              o_push,
    output twp_pkg::t_job     o_job
);
    import twp_pkg::*;

    logic                  r_valid;
    logic                  n_valid;
    t_item                 r_item;
    logic                  accept;
    logic [PROD_BITS-1:0]  prod;

    assign o_busy = r_valid && i_q_status.full;
    assign accept = i_start && !o_busy;
    assign o_push = r_valid && !i_q_status.full;

    always_comb begin
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    // n*(n+1) is always even, so the halving is exact
    assign prod = PROD_BITS'(r_item.entry_count)
                * PROD_BITS'({1'b0, r_item.entry_count} + 1'b1);

    always_comb begin
        o_job.count   = r_item.entry_count;
        o_job.rnd     = r_item.random_word;
        o_job.tri_num = prod[TRI_BITS:1];
        o_job.bad     = (r_item.entry_count == '0);
    end

endmodule

/* hdl/twp_queue.sv */
`timescale 1ns / 1ps
// Short job queue between front end and back end.
// Depends on twp_pkg and the assertion macro header.
`include "triangular_weighted_pick_unit_macros.svh"
module twp_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  twp_pkg::t_job      i_job,
    input  logic               i_pop,
    output twp_pkg::t_job      o_head,
    output twp_pkg::t_q_status o_status
);
    import twp_pkg::*;

    t_job                  r_mem [0:Q_DEPTH-1];
    logic [Q_PTR_BITS-1:0] r_wr_ptr;
    logic [Q_PTR_BITS-1:0] r_rd_ptr;
    logic [Q_CNT_BITS-1:0] r_count;
    logic [Q_PTR_BITS-1:0] n_wr_ptr;
    logic [Q_PTR_BITS-1:0] n_rd_ptr;
    logic [Q_CNT_BITS-1:0] n_count;

    assign o_head             = r_mem[r_rd_ptr];
    assign o_status.full      = (r_count == Q_CNT_BITS'(Q_DEPTH));
    assign o_status.not_empty = (r_count != '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    `TWP_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, i_push, !o_status.full)
    `TWP_ASSERT_NOW(a_no_underflow, i_clk, i_rst_n, i_pop, o_status.not_empty)
    `TWP_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + 1'b1)

endmodule

/* hdl/twp_back.sv */
`timescale 1ns / 1ps
// Back end: pipelined remainder (one quotient bit per stage), pipelined
// integer square root (one root bit per stage) and index mapping. Depends on twp_pkg.
`include "triangular_weighted_pick_unit_macros.svh"
module twp_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  twp_pkg::t_q_status i_q_status,
    input  twp_pkg::t_job      i_head,
    output logic               o_pop,
    output logic               o_valid,
    output twp_pkg::t_result   o_result
);
    import twp_pkg::*;

    // remainder pipeline, stage 0 holds the popped job
    logic                   r_dv_vld [0:RANDOM_BITS];
    logic [COUNT_BITS-1:0]  r_dv_n   [0:RANDOM_BITS];
    logic [RANDOM_BITS-1:0] r_dv_rnd [0:RANDOM_BITS];
    logic [TRI_BITS-1:0]    r_dv_tri [0:RANDOM_BITS];
    logic                   r_dv_bad [0:RANDOM_BITS];
    logic [TRI_BITS-1:0]    r_dv_rem [0:RANDOM_BITS];

    // square root pipeline, stage 0 holds the radicand
    logic                   r_sq_vld  [0:ROOT_BITS];
    logic [COUNT_BITS-1:0]  r_sq_n    [0:ROOT_BITS];
    logic                   r_sq_bad  [0:ROOT_BITS];
    logic [SQ_W-1:0]        r_sq_rem  [0:ROOT_BITS];
    logic [SQ_W-1:0]        r_sq_root [0:ROOT_BITS];

    logic                   r_out_vld;
    t_result                r_out;

    logic [ROOT_BITS-1:0]   root_s;
    logic [ROOT_BITS-1:0]   root_m1;
    logic [COUNT_BITS-1:0]  k_val;
    logic [COUNT_BITS-1:0]  pick;

    // the back end never stalls
    assign o_pop = i_q_status.not_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld[0] <= 1'b0;
        end else begin
            r_dv_vld[0] <= o_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dv_n[0]   <= i_head.count;
        r_dv_rnd[0] <= i_head.rnd;
        r_dv_tri[0] <= i_head.tri_num;
        r_dv_bad[0] <= i_head.bad;
        r_dv_rem[0] <= '0;
    end

    for (genvar s = 1; s <= RANDOM_BITS; s++) begin : g_div
        logic [TRI_BITS:0] rem_sh;
        logic [TRI_BITS:0] diff;
        logic              ge;

        assign rem_sh = {r_dv_rem[s-1], r_dv_rnd[s-1][RANDOM_BITS-s]};
        assign diff   = rem_sh - {1'b0, r_dv_tri[s-1]};
        assign ge     = (rem_sh >= {1'b0, r_dv_tri[s-1]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[s] <= 1'b0;
            end else begin
                r_dv_vld[s] <= r_dv_vld[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_dv_n[s]   <= r_dv_n[s-1];
            r_dv_rnd[s] <= r_dv_rnd[s-1];
            r_dv_tri[s] <= r_dv_tri[s-1];
            r_dv_bad[s] <= r_dv_bad[s-1];
            r_dv_rem[s] <= ge ? diff[TRI_BITS-1:0] : rem_sh[TRI_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld[0] <= 1'b0;
        end else begin
            r_sq_vld[0] <= r_dv_vld[RANDOM_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq_n[0]    <= r_dv_n[RANDOM_BITS];
        r_sq_bad[0]  <= r_dv_bad[RANDOM_BITS];
        r_sq_rem[0]  <= SQ_W'({r_dv_rem[RANDOM_BITS], 3'b001});
        r_sq_root[0] <= '0;
    end

    // digit-by-digit root; a leading zero digit just leaves root at zero
    for (genvar j = 1; j <= ROOT_BITS; j++) begin : g_sqrt
        localparam logic [SQ_W-1:0] SqBit = SQ_W'(1) << (2 * (ROOT_BITS - j));
        logic [SQ_W:0] trial;
        logic          fits;

        assign trial = {1'b0, r_sq_root[j-1]} + {1'b0, SqBit};
        assign fits  = ({1'b0, r_sq_rem[j-1]} >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_vld[j] <= 1'b0;
            end else begin
                r_sq_vld[j] <= r_sq_vld[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_sq_n[j]   <= r_sq_n[j-1];
            r_sq_bad[j] <= r_sq_bad[j-1];
            if (fits) begin
                r_sq_rem[j]  <= r_sq_rem[j-1] - trial[SQ_W-1:0];
                r_sq_root[j] <= (r_sq_root[j-1] >> 1) + SqBit;
            end else begin
                r_sq_rem[j]  <= r_sq_rem[j-1];
                r_sq_root[j] <= r_sq_root[j-1] >> 1;
            end
        end
    end

    // k = (s-1)/2, index = n-1-k
    assign root_s  = r_sq_root[ROOT_BITS][ROOT_BITS-1:0];
    assign root_m1 = root_s - 1'b1;
    assign k_val   = COUNT_BITS'(root_m1[ROOT_BITS-1:1]);
    assign pick    = r_sq_n[ROOT_BITS] - 1'b1 - k_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_sq_vld[ROOT_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out.bad_count  <= r_sq_bad[ROOT_BITS];
        r_out.pick_index <= r_sq_bad[ROOT_BITS] ? '0 : PICK_BITS'(pick);
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_out;

    `TWP_ASSERT_NOW(a_bad_gives_zero, i_clk, i_rst_n, o_valid && o_result.bad_count, o_result.pick_index == '0)
    `TWP_ASSERT_NEXT(a_div_feeds_root, i_clk, i_rst_n, r_dv_vld[RANDOM_BITS], r_sq_vld[0])
    `TWP_ASSERT_NEXT(a_pop_enters_div, i_clk, i_rst_n, o_pop, r_dv_vld[0])

endmodule
